/* design/shn_pkg.sv */
// Shared types and constants of the Sobel height-to-normal block.
package shn_pkg;

    localparam int ROW_MAX     = 4096;
    localparam int COL_W       = $clog2(ROW_MAX);
    localparam int PIX_W       = 8;
    localparam int RL_W        = 13;
    localparam int Z_W         = 16;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_ADDR_W-1:0] CFG_ROW_LENGTH = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_Z_TERM     = 1'b1;

    // One column of the window: upper in the top byte, lower in the bottom byte.
    typedef logic [3*PIX_W-1:0] t_column;

    typedef struct packed {
        t_column left;
        t_column center;
        t_column right;
        logic    run_last;
        logic    image_last;
    } t_job;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_LATER
    } t_row_phase;

    typedef enum logic [1:0] {
        F_IDLE,
        F_CALC,
        F_PUSH
    } t_front_state;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SQUARE,
        B_SUM,
        B_INIT,
        B_MUL_RHS,
        B_STEP,
        B_MUL_CMP,
        B_OUT
    } t_back_state;

    typedef enum logic [1:0] {
        C_X,
        C_Y,
        C_Z
    } t_comp;

endpackage

/* design/sobel_height_to_normal_map.sv */
// Top level of the Sobel height-map to normal-map converter.
//
// Usage: height bytes enter on the s_axis channel in raster order, one pixel per request;
// tuser set marks a drain request that stands for the clamped row below the last row.
// After the image, send one full row of drain requests to flush the final normals.
// Normals leave on the m_axis channel as red, green, blue bytes; tuser marks the last
// normal caused by one input request, tlast marks the final normal of the image.
// Output lags input by one row: a pixel's normal leaves once the pixel below and to the
// right of it has arrived. Flow: the front end reads the stores, updates the window and
// makes one queue push per normal; a drain request in the first row is dropped. The
// back end's pace is set by the shift-add multiplier (one bit a cycle): per component
// a squaring and up to 8 compares; the back end sets the rate. A four-entry queue sits
// between the two halves; the output register lets the back end finish the next
// normal while the receiver stalls, then it holds.
// Reset (synchronous, active low) returns to the first row, clears the window, sets the
// row length to 4096 and the flat term to 8160. The line stores are not cleared.
// Configuration writes (index 0 row length, index 1 flat term) take effect at once; the user
// is to make them only while the block is idle, and the block itself does not enforce this.
module sobel_height_to_normal_map (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [shn_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [shn_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [7:0]                        i_s_axis_tdata,  // [7:0] height_sample
    input  logic                              i_s_axis_tuser,  // [0] drain
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [23:0]                       o_m_axis_tdata,  // [7:0] red, [15:8] green,
                                                               // [23:16] blue
    output logic                              o_m_axis_tlast,  // image_last
    output logic                              o_m_axis_tuser   // [0] run_last
);
    import shn_pkg::*;

    logic [RL_W-1:0] r_row_length;
    logic [Z_W-1:0]  r_z_term;

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_job w_job_in;
    t_job w_job_out;

    // Hold configuration registers; write with no wait
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= RL_W'(ROW_MAX);
            r_z_term     <= Z_W'(8160);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_ROW_LENGTH: r_row_length <= i_cfg_wdata[RL_W-1:0];
                CFG_Z_TERM:     r_z_term     <= i_cfg_wdata[Z_W-1:0];
                default: begin
                end
            endcase
        end
    end

    shn_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_row_length (r_row_length),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_pixel      (i_s_axis_tdata),
        .i_drain      (i_s_axis_tuser),
        .i_q_full     (w_full),
        .o_push       (w_push),
        .o_job        (w_job_in)
    );

    shn_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .i_pop   (w_pop),
        .o_job   (w_job_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    shn_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_z_term     (r_z_term),
        .i_q_empty    (w_empty),
        .i_job        (w_job_out),
        .o_pop        (w_pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_data       (o_m_axis_tdata),
        .o_run_last   (o_m_axis_tuser),
        .o_image_last (o_m_axis_tlast)
    );

    // The front end never pushes into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_full) else $error("queue overflow");

    // The back end never pops an empty queue
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty) else $error("queue underflow");

    // The image end is always the last normal of its request
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tlast) |-> o_m_axis_tuser)
        else $error("image end without request end");

    // Blue comes from a negative z component
    a_blue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_m_axis_tdata[23]) else $error("blue above 127");

endmodule

/* design/shn_queue.sv */
// Short job queue between the window front end and the normalizing back end.
module shn_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  shn_pkg::t_job i_job,
    input  logic        i_pop,
    output shn_pkg::t_job o_job,
    output logic        o_full,
    output logic        o_empty
);
    import shn_pkg::*;

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QPTR_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QPTR_W+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

/* design/shn_front.sv */
// Front end: takes height pixels, keeps the line stores and window, queues windows.
module shn_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [shn_pkg::RL_W-1:0]    i_row_length,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [shn_pkg::PIX_W-1:0]   i_pixel,
    input  logic                        i_drain,
    input  logic                        i_q_full,
    output logic                        o_push,
    output shn_pkg::t_job               o_job
);
    import shn_pkg::*;

    logic [PIX_W-1:0] r_upper [ROW_MAX];
    logic [PIX_W-1:0] r_middle [ROW_MAX];

    t_front_state     r_state;
    t_front_state     n_state;
    t_row_phase       r_phase;
    logic [COL_W-1:0] r_col;
    t_column          r_win0;
    t_column          r_win1;
    logic [PIX_W-1:0] r_pix;
    logic             r_drain;
    logic [PIX_W-1:0] r_up_q;
    logic [PIX_W-1:0] r_mid_q;
    t_job             r_job1;
    t_job             r_job2;
    logic             r_e1;
    logic             r_e2;

    logic             w_accept;
    logic             w_drop;
    logic [COL_W-1:0] w_last_col;
    logic             w_last;
    logic [PIX_W-1:0] w_up;
    logic [PIX_W-1:0] w_low;
    t_column          w_col;
    t_column          w_nwin0;
    logic             w_e1;
    logic             w_e2;

    assign w_accept = i_valid && o_ready;
    assign w_drop   = i_drain && (r_phase == PH_FIRST);

    // Clamp the row length into 1 .. ROW_MAX.
    always_comb begin
        if (i_row_length == '0) begin
            w_last_col = '0;
        end else if (i_row_length > RL_W'(ROW_MAX)) begin
            w_last_col = COL_W'(ROW_MAX - 1);
        end else begin
            w_last_col = COL_W'(i_row_length - 1'b1);
        end
    end

    assign w_last  = (r_col >= w_last_col);
    assign w_up    = (r_phase == PH_LATER) ? r_up_q : r_mid_q;
    assign w_low   = r_drain ? r_mid_q : r_pix;
    assign w_col   = {w_up, r_mid_q, w_low};
    assign w_nwin0 = (r_col == '0) ? w_col : r_win1;
    assign w_e1    = (r_col != '0) && (r_phase != PH_FIRST);
    assign w_e2    = w_last && (r_phase != PH_FIRST);

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (w_accept && !w_drop) begin
                    n_state = F_CALC;
                end
            end
            F_CALC: n_state = F_PUSH;
            F_PUSH: begin
                if ((!r_e1 && !r_e2) || (o_push && !(r_e1 && r_e2))) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_ready = (r_state == F_IDLE);
        o_push  = (r_state == F_PUSH) && (r_e1 || r_e2) && !i_q_full;
        o_job   = r_e1 ? r_job1 : r_job2;
    end

    // Line stores: read at acceptance, write back once the column is formed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_up_q  <= r_upper[r_col];
            r_mid_q <= r_middle[r_col];
        end
        if (r_state == F_CALC) begin
            if (r_phase == PH_FIRST) begin
                r_middle[r_col] <= r_pix;
            end else begin
                r_upper[r_col]  <= r_mid_q;
                r_middle[r_col] <= w_low;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pix   <= i_pixel;
            r_drain <= i_drain;
        end
        if (r_state == F_CALC) begin
            r_job1.left       <= r_win0;
            r_job1.center     <= r_win1;
            r_job1.right      <= w_col;
            r_job1.run_last   <= !w_e2;
            r_job1.image_last <= 1'b0;
            r_job2.left       <= w_nwin0;
            r_job2.center     <= w_col;
            r_job2.right      <= w_col;
            r_job2.run_last   <= 1'b1;
            r_job2.image_last <= r_drain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
            r_phase <= PH_FIRST;
            r_col   <= '0;
            r_win0  <= '0;
            r_win1  <= '0;
            r_e1    <= 1'b0;
            r_e2    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == F_CALC) begin
                r_e1   <= w_e1;
                r_e2   <= w_e2;
                r_win0 <= w_nwin0;
                r_win1 <= w_col;
                if (w_last) begin
                    r_col <= '0;
                    if (r_drain) begin
                        r_phase <= PH_FIRST;
                    end else if (r_phase == PH_FIRST) begin
                        r_phase <= PH_SECOND;
                    end else begin
                        r_phase <= PH_LATER;
                    end
                end else begin
                    r_col <= r_col + 1'b1;
                end
            end
            if (o_push) begin
                if (r_e1) begin
                    r_e1 <= 1'b0;
                end else begin
                    r_e2 <= 1'b0;
                end
            end
        end
    end

endmodule

/* design/shn_back.sv */
// Back end: Sobel gradients, normalization by exact search, byte mapping.
module shn_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [shn_pkg::Z_W-1:0]   i_z_term,
    input  logic                      i_q_empty,
    input  shn_pkg::t_job             i_job,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [23:0]               o_data,
    output logic                      o_run_last,
    output logic                      o_image_last
);
    import shn_pkg::*;

    localparam int GW   = 12;
    localparam int AW   = 11;
    localparam int SQW  = 22;
    localparam int LW   = 38;
    localparam int PW   = 54;
    localparam int RW   = 27;
    localparam int CW   = 5;

    t_back_state      r_state;
    t_back_state      n_state;
    t_job             r_job;
    logic [AW-1:0]    r_ax;
    logic [AW-1:0]    r_ay;
    logic             r_nx;
    logic             r_ny;
    logic [SQW-1:0]   r_gx2;
    logic [SQW-1:0]   r_gy2;
    logic [2*Z_W-1:0] r_z2;
    logic [Z_W-1:0]   r_z;
    logic [LW-1:0]    r_len2;
    t_comp            r_idx;
    logic             r_neg;
    logic [7:0]       r_lo;
    logic [7:0]       r_hi;
    logic [7:0]       r_k;
    logic             r_dneg;
    logic [PW-1:0]    r_rhs2;
    logic [PW-1:0]    r_acc;
    logic [PW-1:0]    r_mcand;
    logic [RW-1:0]    r_mplier;
    logic [CW-1:0]    r_cnt;
    logic [7:0]       r_red;
    logic [7:0]       r_green;
    logic [7:0]       r_blue;
    logic             r_out_valid;
    logic [23:0]      r_out_data;
    logic             r_out_run;
    logic             r_out_img;

    logic signed [GW-1:0] w_gx;
    logic signed [GW-1:0] w_gy_r;
    logic [AW-1:0]    w_ax;
    logic [AW-1:0]    w_ay;
    logic [Z_W-1:0]   w_z;
    logic [18:0]      w_mag;
    logic             w_neg;
    logic [RW-1:0]    w_rhs;
    logic [PW-1:0]    w_sum;
    logic [8:0]       w_k9;
    logic [7:0]       w_k;
    logic [7:0]       w_dabs;
    logic [15:0]      w_dsq;
    logic             w_ok;
    logic             w_load;

    function automatic logic signed [GW-1:0] sx(input logic [PIX_W-1:0] v);
        sx = $signed({{(GW-PIX_W){1'b0}}, v});
    endfunction

    // Gradients: upper byte [23:16], middle [15:8], lower [7:0]
    assign w_gx = sx(r_job.left[23:16]) + (sx(r_job.left[15:8]) <<< 1)
                + sx(r_job.left[7:0]) - sx(r_job.right[23:16])
                - (sx(r_job.right[15:8]) <<< 1) - sx(r_job.right[7:0]);

    assign w_gy_r = sx(r_job.left[23:16]) + (sx(r_job.center[23:16]) <<< 1)
                  + sx(r_job.right[23:16]) - sx(r_job.left[7:0])
                  - (sx(r_job.center[7:0]) <<< 1) - sx(r_job.right[7:0]);

    assign w_ax = w_gx[GW-1] ? AW'(-w_gx) : AW'(w_gx);
    assign w_ay = w_gy_r[GW-1] ? AW'(-w_gy_r) : AW'(w_gy_r);
    assign w_z  = (i_z_term == '0) ? Z_W'(1) : i_z_term;

    // Component selection: the normal is -(gx*256, gy*256, z)
    always_comb begin
        case (r_idx)
            C_X: begin
                w_mag = {r_ax, 8'b0};
                w_neg = r_nx;
            end
            C_Y: begin
                w_mag = {r_ay, 8'b0};
                w_neg = r_ny;
            end
            default: begin
                w_mag = {3'b0, r_z};
                w_neg = 1'b1;
            end
        endcase
    end

    assign w_rhs  = {w_mag, 8'b0} - {8'b0, w_mag};
    assign w_sum  = r_acc + (r_mplier[0] ? r_mcand : '0);
    assign w_k9   = {1'b0, r_lo} + {1'b0, r_hi} + 9'd1;
    assign w_k    = w_k9[8:1];
    assign w_dabs = {w_k[7] ? w_k[6:0] : ~w_k[6:0], 1'b1};
    assign w_dsq  = w_dabs * w_dabs;
    assign w_ok   = r_dneg ? (w_sum >= r_rhs2) : (w_sum <= r_rhs2);
    assign w_load = !r_out_valid || i_ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE:    if (!i_q_empty) n_state = B_SQUARE;
            B_SQUARE:  n_state = B_SUM;
            B_SUM:     n_state = B_INIT;
            B_INIT:    n_state = B_MUL_RHS;
            B_MUL_RHS: if (r_cnt == CW'(1)) n_state = B_STEP;
            B_STEP: begin
                if (r_lo == r_hi) begin
                    n_state = (r_idx == C_Z) ? B_OUT : B_INIT;
                end else if (w_k[7] != w_neg) begin
                    n_state = B_MUL_CMP;
                end
            end
            B_MUL_CMP: if (r_cnt == CW'(1)) n_state = B_STEP;
            B_OUT:     if (w_load) n_state = B_IDLE;
            default:   n_state = B_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_pop        = (r_state == B_IDLE) && !i_q_empty;
        o_valid      = r_out_valid;
        o_data       = r_out_data;
        o_run_last   = r_out_run;
        o_image_last = r_out_img;
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            B_IDLE: begin
                r_job <= i_job;
            end
            B_SQUARE: begin
                r_ax  <= w_ax;
                r_ay  <= w_ay;
                r_nx  <= !w_gx[GW-1] && (w_gx != '0);
                r_ny  <= !w_gy_r[GW-1] && (w_gy_r != '0);
                r_gx2 <= SQW'(w_ax * w_ax);
                r_gy2 <= SQW'(w_ay * w_ay);
                r_z2  <= w_z * w_z;
                r_z   <= w_z;
            end
            B_SUM: begin
                r_len2 <= {r_gx2, 16'b0} + {r_gy2, 16'b0} + LW'(r_z2);
            end
            B_INIT: begin
                r_neg    <= w_neg;
                r_lo     <= '0;
                r_hi     <= 8'd255;
                r_acc    <= '0;
                r_mcand  <= PW'(w_rhs);
                r_mplier <= w_rhs;
                r_cnt    <= CW'(RW);
            end
            B_MUL_RHS, B_MUL_CMP: begin
                r_acc    <= w_sum;
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                r_cnt    <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    if (r_state == B_MUL_RHS) begin
                        r_rhs2 <= w_sum;
                    end else if (w_ok) begin
                        r_lo <= r_k;
                    end else begin
                        r_hi <= r_k - 1'b1;
                    end
                end
            end
            B_STEP: begin
                if (r_lo == r_hi) begin
                    case (r_idx)
                        C_X:     r_red   <= r_lo;
                        C_Y:     r_green <= r_lo;
                        default: r_blue  <= r_lo;
                    endcase
                end else if (!w_k[7] && !r_neg) begin
                    r_lo <= w_k;
                end else if (w_k[7] && r_neg) begin
                    r_hi <= w_k - 1'b1;
                end else begin
                    // Signs agree: compare d^2*len2 against (255*|c|)^2
                    r_k      <= w_k;
                    r_dneg   <= !w_k[7];
                    r_acc    <= '0;
                    r_mcand  <= PW'(r_len2);
                    r_mplier <= RW'(w_dsq);
                    r_cnt    <= CW'(16);
                end
            end
            default: begin
            end
        endcase
        if ((r_state == B_OUT) && w_load) begin
            r_out_data <= {r_blue, r_green, r_red};
            r_out_run  <= r_job.run_last;
            r_out_img  <= r_job.image_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_idx       <= C_X;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_SUM) begin
                r_idx <= C_X;
            end else if ((r_state == B_STEP) && (r_lo == r_hi)) begin
                case (r_idx)
                    C_X:     r_idx <= C_Y;
                    C_Y:     r_idx <= C_Z;
                    default: r_idx <= C_X;
                endcase
            end
            if ((r_state == B_OUT) && w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule
